@@ sv/sbmq_pkg.sv @@
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and codes for the shared-buffer multi-queue block.
// ----------------------------------------------------------------------------
package sbmq_pkg;

   typedef enum logic [0:0] {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_PUSH_LINK,
      S_POP_LINK,
      S_HOLD
   } state_type;

   localparam int DATA_OUT_W = 32;

endpackage

@@ sv/shared_buffer_multi_queue_top.sv @@
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// QUEUE_COUNT FIFO queues sharing one slot store through a linked free list.
//
// Request channel (req_*): one beat is a push of req_value onto queue
// req_queue_id, or a pop from it. Response channel (rsp_*): one beat per
// request, in order, with rsp_status (done / full / empty) and rsp_data_out
// (popped word, zero otherwise).
// A request beat first reads the queue table. A refused push or an empty
// pop answers from that read; a push or pop that succeeds goes on to read
// the slot link, then writes back links and pointers and answers. The next
// request is taken in the cycle after the answer is loaded, so a new request
// is not taken before the last one is answered.
// The response sits in an output register; while it waits under rsp_stall
// the block still takes and works on the next request, parking that result
// in a hold register and stalling further requests until the output frees.
// Reset: all queues empty, every slot free. The link store needs no clearing
// pass: slots never yet handed out are tracked by a fill count and read as
// linking to the next slot.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_top import sbmq_pkg::*; #(
   parameter int SLOT_COUNT  = 16,
   parameter int QUEUE_COUNT = 4,
   parameter int DATA_WIDTH  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [0:0]         req_kind,
   input  logic [1:0]         req_queue_id,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data_out
);

   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int LINK_W  = $clog2(SLOT_COUNT + 1);
   localparam int QUEUE_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(SLOT_COUNT);
   localparam logic [2:0] QC_WRAP = 3'((QUEUE_COUNT > 4) ? 4 : QUEUE_COUNT);

   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [QUEUE_W-1:0]    qid_ff, qid_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic                  linked_ff, linked_in;
   logic                  fresh_hit_ff, fresh_hit_in;
   logic [LINK_W-1:0]     free_head_ff, free_head_in;
   logic [LINK_W-1:0]     fresh_ff, fresh_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_OUT_W-1:0] rsp_data_ff, rsp_data_in;
   status_type            hold_status_ff, hold_status_in;
   logic [DATA_OUT_W-1:0] hold_data_ff, hold_data_in;

   logic [QUEUE_W-1:0]    qsel;
   logic [2:0]            qwrap;
   logic                  q_rd_en, q_wr_en;
   logic [LINK_W-1:0]     q_head_rd, q_wr_head;
   logic [SLOT_W-1:0]     q_tail_rd, q_wr_tail;
   logic                  s_rd_en, link_we, data_we;
   logic [SLOT_W-1:0]     s_rd_addr, s_wr_addr;
   logic [LINK_W-1:0]     link_wd, link_rd;
   logic [DATA_WIDTH-1:0] data_rd;
   logic                  fin, out_free;
   status_type            fin_status;
   logic [DATA_OUT_W-1:0] fin_data;

   // queue number wraps modulo QUEUE_COUNT (id is only 2 bits)
   always_comb begin
      qwrap = {1'b0, req_queue_id};
      for (int i = 0; i < 3; i++) begin
         if (qwrap >= QC_WRAP) begin
            qwrap = qwrap - QC_WRAP;
         end
      end
      qsel = QUEUE_W'(qwrap);
   end

   sbmq_queue_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .QUEUE_COUNT(QUEUE_COUNT),
      .QUEUE_W    (QUEUE_W),
      .SLOT_W     (SLOT_W),
      .LINK_W     (LINK_W)
   ) u_queue_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (q_rd_en),
      .rd_addr(qsel),
      .rd_head(q_head_rd),
      .rd_tail(q_tail_rd),
      .wr_en  (q_wr_en),
      .wr_addr(qid_ff),
      .wr_head(q_wr_head),
      .wr_tail(q_wr_tail)
   );

   sbmq_slot_mem #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_W    (SLOT_W),
      .LINK_W    (LINK_W),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_slot_mem (
      .clock  (clock),
      .wr_addr(s_wr_addr),
      .link_we(link_we),
      .link_wd(link_wd),
      .data_we(data_we),
      .data_wd(value_ff),
      .rd_en  (s_rd_en),
      .rd_addr(s_rd_addr),
      .link_rd(link_rd),
      .data_rd(data_rd)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      qid_in         = qid_ff;
      value_in       = value_ff;
      slot_in        = slot_ff;
      tail_in        = tail_ff;
      linked_in      = linked_ff;
      fresh_hit_in   = fresh_hit_ff;
      free_head_in   = free_head_ff;
      fresh_in       = fresh_ff;
      hold_status_in = hold_status_ff;
      hold_data_in   = hold_data_ff;
      q_rd_en        = 1'b0;
      q_wr_en        = 1'b0;
      q_wr_head      = '0;
      q_wr_tail      = '0;
      s_rd_en        = 1'b0;
      s_rd_addr      = '0;
      s_wr_addr      = '0;
      link_we        = 1'b0;
      link_wd        = '0;
      data_we        = 1'b0;
      fin            = 1'b0;
      fin_status     = ST_DONE;
      fin_data       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_rd_en  = 1'b1;
               kind_in  = kind_type'(req_kind);
               qid_in   = qsel;
               value_in = DATA_WIDTH'($unsigned(req_value));
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (kind_ff == KIND_PUSH) begin
               if (free_head_ff == NULL_SLOT) begin
                  fin        = 1'b1;
                  fin_status = ST_FULL;
               end else begin
                  slot_in   = free_head_ff[SLOT_W-1:0];
                  s_wr_addr = free_head_ff[SLOT_W-1:0];
                  link_we   = 1'b1;
                  link_wd   = NULL_SLOT;
                  data_we   = 1'b1;
                  // old link of the taken slot gives the next free head
                  s_rd_en   = 1'b1;
                  s_rd_addr = free_head_ff[SLOT_W-1:0];
                  fresh_hit_in = (free_head_ff == fresh_ff);
                  if (free_head_ff == fresh_ff) begin
                     fresh_in = fresh_ff + LINK_W'(1);
                  end
                  q_wr_en   = 1'b1;
                  q_wr_head = (q_head_rd == NULL_SLOT) ? free_head_ff : q_head_rd;
                  q_wr_tail = free_head_ff[SLOT_W-1:0];
                  tail_in   = q_tail_rd;
                  linked_in = (q_head_rd != NULL_SLOT);
                  state_in  = S_PUSH_LINK;
               end
            end else begin
               if (q_head_rd == NULL_SLOT) begin
                  fin        = 1'b1;
                  fin_status = ST_EMPTY;
               end else begin
                  slot_in   = q_head_rd[SLOT_W-1:0];
                  s_rd_en   = 1'b1;
                  s_rd_addr = q_head_rd[SLOT_W-1:0];
                  tail_in   = q_tail_rd;
                  state_in  = S_POP_LINK;
               end
            end
         end
         S_PUSH_LINK: begin
            // a never-used slot links to the one after it
            free_head_in = fresh_hit_ff ? (LINK_W'(slot_ff) + LINK_W'(1)) : link_rd;
            if (linked_ff) begin
               link_we   = 1'b1;
               s_wr_addr = tail_ff;
               link_wd   = LINK_W'(slot_ff);
            end
            fin        = 1'b1;
            fin_status = ST_DONE;
         end
         S_POP_LINK: begin
            q_wr_en      = 1'b1;
            q_wr_head    = link_rd;
            q_wr_tail    = tail_ff;
            link_we      = 1'b1;
            s_wr_addr    = slot_ff;
            link_wd      = free_head_ff;
            free_head_in = LINK_W'(slot_ff);
            fin          = 1'b1;
            fin_status   = ST_DONE;
            fin_data     = DATA_OUT_W'(data_rd);
         end
         S_HOLD: begin
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register, with a hold stage behind it
      out_free      = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (fin) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = fin_status;
            rsp_data_in   = fin_data;
            state_in      = S_IDLE;
         end else begin
            hold_status_in = fin_status;
            hold_data_in   = fin_data;
            state_in       = S_HOLD;
         end
      end else if (state_ff == S_HOLD && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = hold_status_ff;
         rsp_data_in   = hold_data_ff;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         fresh_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      qid_ff         <= qid_in;
      value_ff       <= value_in;
      slot_ff        <= slot_in;
      tail_ff        <= tail_in;
      linked_ff      <= linked_in;
      fresh_hit_ff   <= fresh_hit_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      hold_status_ff <= hold_status_in;
      hold_data_ff   <= hold_data_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = signed'(rsp_data_ff);

endmodule

@@ sv/sbmq_queue_mem.sv @@
// ----------------------------------------------------------------------------
// sbmq_queue_mem
// Per-queue head/tail table. One write and one registered read per cycle;
// a queue never written reads back with a null head.
// ----------------------------------------------------------------------------
module sbmq_queue_mem import sbmq_pkg::*; #(
   parameter int SLOT_COUNT  = 16,
   parameter int QUEUE_COUNT = 4,
   parameter int QUEUE_W     = 2,
   parameter int SLOT_W      = 4,
   parameter int LINK_W      = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [QUEUE_W-1:0] rd_addr,
   output logic [LINK_W-1:0]  rd_head,
   output logic [SLOT_W-1:0]  rd_tail,
   input  logic               wr_en,
   input  logic [QUEUE_W-1:0] wr_addr,
   input  logic [LINK_W-1:0]  wr_head,
   input  logic [SLOT_W-1:0]  wr_tail
);

   localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(SLOT_COUNT);

   logic [LINK_W+SLOT_W-1:0] mem [QUEUE_COUNT];
   logic [QUEUE_COUNT-1:0]   vld_ff;
   logic [LINK_W+SLOT_W-1:0] rd_word_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_head, wr_tail};
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_head = rd_vld_ff ? rd_word_ff[LINK_W+SLOT_W-1:SLOT_W] : NULL_SLOT;
   assign rd_tail = rd_word_ff[SLOT_W-1:0];

endmodule

@@ sv/sbmq_slot_mem.sv @@
// ----------------------------------------------------------------------------
// sbmq_slot_mem
// Slot store: next-slot link and data word per slot. Shared write address,
// one registered read address for both arrays (read returns old data).
// ----------------------------------------------------------------------------
module sbmq_slot_mem import sbmq_pkg::*; #(
   parameter int SLOT_COUNT = 16,
   parameter int SLOT_W     = 4,
   parameter int LINK_W     = 5,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [SLOT_W-1:0]     wr_addr,
   input  logic                  link_we,
   input  logic [LINK_W-1:0]     link_wd,
   input  logic                  data_we,
   input  logic [DATA_WIDTH-1:0] data_wd,
   input  logic                  rd_en,
   input  logic [SLOT_W-1:0]     rd_addr,
   output logic [LINK_W-1:0]     link_rd,
   output logic [DATA_WIDTH-1:0] data_rd
);

   logic [LINK_W-1:0]     link_mem [SLOT_COUNT];
   logic [DATA_WIDTH-1:0] data_mem [SLOT_COUNT];
   logic [LINK_W-1:0]     link_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wd;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[wr_addr] <= data_wd;
      end
      if (rd_en) begin
         data_rd_ff <= data_mem[rd_addr];
      end
   end

   assign link_rd = link_rd_ff;
   assign data_rd = data_rd_ff;

endmodule
